### rtl/core/trrq_pkg.sv
// Shared types, constants and the record length table for the typed record ring queue.
// No dependencies; every other file depends on this package.
package trrq_pkg;

  localparam int RING_BYTES_DEF = 256;
  localparam int PAYLOAD_W      = 56;
  localparam int REQ_W          = 2;
  localparam int IDX_W          = 3;

  // Request codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_KEY      = 2'd0,
    REQ_CONSUMER = 2'd1,
    REQ_MOUSE    = 2'd2,
    REQ_DEQUEUE  = 2'd3
  } req_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic enq_start;
    logic enq_write;
    logic deq_start;
    logic deq_type;
    logic deq_step;
    logic deq_commit;
    logic clear;
    logic res_load;
    logic res_ok;
    logic res_corrupt;
  } trrq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_deq;
    logic no_room;
    logic empty;
    logic wr_last;
    logic type_bad;
    logic issue_done;
    logic at_wp;
    logic rd_pend;
  } trrq_stat_t;

  // Payload byte count of a record type; zero for a code that is no record
  function automatic logic [IDX_W-1:0] rec_len(input logic [REQ_W-1:0] t);
    logic [IDX_W-1:0] len;
    case (t)
      REQ_KEY:      len = 3'd7;
      REQ_CONSUMER: len = 3'd2;
      REQ_MOUSE:    len = 3'd4;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/trrq_if.sv
// Valid/ready channel interfaces for requests and results of the typed record ring queue.
// Depends on trrq_pkg for field widths.
interface trrq_req_if;
  logic                            valid;
  logic                            ready;
  logic [trrq_pkg::REQ_W-1:0]      req_type;
  logic [trrq_pkg::PAYLOAD_W-1:0]  payload;

  modport source(output valid, req_type, payload, input ready);
  modport sink(input valid, req_type, payload, output ready);
endinterface

interface trrq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [trrq_pkg::REQ_W-1:0]      rec_type;
  logic [trrq_pkg::PAYLOAD_W-1:0]  rec_payload;
  logic                            corrupt;

  modport source(output valid, ok, rec_type, rec_payload, corrupt, input ready);
  modport sink(input valid, ok, rec_type, rec_payload, corrupt, output ready);
endinterface

### rtl/core/trrq_dp.sv
// Datapath of the typed record ring queue: byte ring memory, pointers, cursors,
// record assembly and the result register. Depends on trrq_pkg.
module trrq_dp #(
  parameter int RING_BYTES = trrq_pkg::RING_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  trrq_pkg::trrq_cmd_t             cmd,
  output trrq_pkg::trrq_stat_t            stat,
  input  logic [trrq_pkg::REQ_W-1:0]      in_req_type,
  input  logic [trrq_pkg::PAYLOAD_W-1:0]  in_payload,
  output logic                            res_ok,
  output logic [trrq_pkg::REQ_W-1:0]      res_type,
  output logic [trrq_pkg::PAYLOAD_W-1:0]  res_payload,
  output logic                            res_corrupt
);
  import trrq_pkg::*;

  localparam int PTR_W = $clog2(RING_BYTES);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] RB_C   = CNT_W'(RING_BYTES);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(RING_BYTES - 1);

  logic [7:0]           mem [RING_BYTES];
  logic [7:0]           rdata;
  logic [PTR_W-1:0]     wp;
  logic [PTR_W-1:0]     rp;
  logic [PTR_W-1:0]     cur;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     cap;
  logic [IDX_W-1:0]     len_q;
  logic [REQ_W-1:0]     req_q;
  logic [REQ_W-1:0]     type_q;
  logic [PAYLOAD_W-1:0] pay_q;
  logic [PAYLOAD_W-1:0] rec;
  logic                 rd_pend;

  logic [CNT_W-1:0]     used;
  logic [CNT_W-1:0]     free_slots;
  logic [CNT_W-1:0]     need;
  logic [IDX_W-1:0]     byte_sel;
  logic [7:0]           wbyte;
  logic                 mem_we;
  logic [PTR_W-1:0]     mem_waddr;
  logic                 mem_re;
  logic [PTR_W-1:0]     mem_raddr;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  // Occupancy and room check for the pending enqueue
  always_comb begin
    if (wp >= rp) begin
      used = CNT_W'(wp) - CNT_W'(rp);
    end else begin
      used = CNT_W'(wp) + RB_C - CNT_W'(rp);
    end
    free_slots = RB_C - CNT_W'(1) - used;
    need       = CNT_W'(rec_len(req_q)) + CNT_W'(1);
  end

  // Byte to store: type byte first, then payload bytes in order
  always_comb begin
    byte_sel = IDX_W'(idx - 1'b1);
    wbyte    = (idx == '0) ? {6'b0, req_q} : pay_q[{byte_sel, 3'b000} +: 8];
  end

  assign mem_we    = cmd.enq_write;
  assign mem_waddr = cur;
  assign mem_re    = cmd.deq_start || (cmd.deq_step && !stat.issue_done);
  assign mem_raddr = cmd.deq_start ? rp : cur;

  // Ring memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wbyte;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else if (cmd.clear) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (cmd.enq_write && stat.wr_last) begin
        wp <= ptr_next(cur);
      end
      if (cmd.deq_commit) begin
        rp <= cur;
      end
    end
  end

  // Cursor, counters and record assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      if (cmd.deq_type) begin
        rd_pend <= 1'b0;
      end else if (cmd.deq_step) begin
        rd_pend <= !stat.issue_done;
      end
    end
    if (cmd.load) begin
      req_q <= in_req_type;
      pay_q <= in_payload;
    end
    if (cmd.enq_start) begin
      cur <= wp;
      idx <= '0;
    end
    if (cmd.enq_write) begin
      cur <= ptr_next(cur);
      idx <= IDX_W'(idx + 1'b1);
    end
    if (cmd.deq_start) begin
      cur <= ptr_next(rp);
      rec <= '0;
    end
    if (cmd.deq_type) begin
      type_q <= rdata[REQ_W-1:0];
      len_q  <= rec_len(rdata[REQ_W-1:0]);
      idx    <= '0;
      cap    <= '0;
    end
    if (cmd.deq_step) begin
      if (rd_pend) begin
        rec[{cap, 3'b000} +: 8] <= rdata;
        cap <= IDX_W'(cap + 1'b1);
      end
      if (!stat.issue_done) begin
        cur <= ptr_next(cur);
        idx <= IDX_W'(idx + 1'b1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_ok      <= cmd.res_ok;
      res_corrupt <= cmd.res_corrupt;
      if (cmd.res_ok && req_q == REQ_DEQUEUE) begin
        res_type    <= type_q;
        res_payload <= rec;
      end else begin
        res_type    <= '0;
        res_payload <= '0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    stat.in_deq     = (in_req_type == REQ_DEQUEUE);
    stat.no_room    = (need > free_slots);
    stat.empty      = (rp == wp);
    stat.wr_last    = (idx == rec_len(req_q));
    stat.type_bad   = (rdata > 8'(REQ_MOUSE));
    stat.issue_done = (idx == len_q);
    stat.at_wp      = (cur == wp);
    stat.rd_pend    = rd_pend;
  end

endmodule

### rtl/core/trrq_ctrl.sv
// Controller state machine of the typed record ring queue: sequences enqueue writes
// and dequeue reads, and owns the handshakes. Depends on trrq_pkg.
module trrq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  trrq_pkg::trrq_stat_t stat,
  output trrq_pkg::trrq_cmd_t  cmd
);
  import trrq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ENQ_CHK  = 6'b000010,
    S_ENQ_WR   = 6'b000100,
    S_DEQ_CHK  = 6'b001000,
    S_DEQ_TYPE = 6'b010000,
    S_DEQ_RUN  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.in_deq ? S_DEQ_CHK : S_ENQ_CHK;
        end
      end
      S_ENQ_CHK: begin
        if (stat.no_room) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.enq_start = 1'b1;
          state_next    = S_ENQ_WR;
        end
      end
      S_ENQ_WR: begin
        if (!stat.wr_last) begin
          cmd.enq_write = 1'b1;
        end else if (out_free) begin
          cmd.enq_write = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_ok    = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DEQ_CHK: begin
        if (stat.empty) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.deq_start = 1'b1;
          state_next    = S_DEQ_TYPE;
        end
      end
      S_DEQ_TYPE: begin
        if (stat.type_bad) begin
          if (out_free) begin
            cmd.clear       = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_corrupt = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.deq_type = 1'b1;
          state_next   = S_DEQ_RUN;
        end
      end
      S_DEQ_RUN: begin
        if (!stat.issue_done && stat.at_wp) begin
          // record cut short by the write pointer
          if (out_free) begin
            cmd.clear       = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_corrupt = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (stat.issue_done && !stat.rd_pend) begin
          if (out_free) begin
            cmd.deq_commit = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_ok     = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.deq_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/typed_report_ring_queue.sv
// Typed record ring queue: a byte ring of RING_BYTES entries holding key report
// (7 payload bytes), consumer (2) and mouse (4) records, each led by a type byte.
// One request is handled at a time, one byte of the ring per cycle; the last
// byte of an enqueue and every result wait until the output is free. The next
// request is accepted the cycle after a result is loaded, even while that
// result waits on the output. A dequeue that finds a bad type byte or a record
// cut short returns corrupt and resets both pointers. Depends on trrq_pkg,
// trrq_if, trrq_ctrl and trrq_dp.
module typed_report_ring_queue #(
  parameter int RING_BYTES = trrq_pkg::RING_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  trrq_req_if.sink          req,
  trrq_rsp_if.source        rsp
);
  import trrq_pkg::*;

  trrq_cmd_t  cmd;
  trrq_stat_t stat;

  trrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  trrq_dp #(
    .RING_BYTES (RING_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (req.req_type),
    .in_payload  (req.payload),
    .res_ok      (rsp.ok),
    .res_type    (rsp.rec_type),
    .res_payload (rsp.rec_payload),
    .res_corrupt (rsp.corrupt)
  );

  // A corruption result leaves the ring empty
  assert property (@(posedge clk) disable iff (rst)
    (cmd.res_load && cmd.res_corrupt) |=> stat.empty)
    else $error("ring not emptied after corruption");

  // A new result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten while pending");

  // Busy in the cycle after each accepted request
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted back to back");

  // Good and corrupt are never reported together
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.ok && rsp.corrupt))
    else $error("ok and corrupt both set");

endmodule

### tb/tb_typed_report_ring_queue.sv
// Self-checking testbench for typed_report_ring_queue: a directed stimulus table, then
// randomized fill/drain phases checked against a behavioral ring image kept in the bench.
// Depends on trrq_pkg, the trrq_req_if/trrq_rsp_if interfaces and the RTL top level.
module tb_typed_report_ring_queue;
  import trrq_pkg::*;

  localparam int RING           = RING_BYTES_DEF;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 24;

  // One response as seen on the result channel
  typedef struct packed {
    logic                 ok;
    logic [REQ_W-1:0]     rec_type;
    logic [PAYLOAD_W-1:0] rec_payload;
    logic                 corrupt;
  } ring_resp_t;

  // One row of the directed table; fixed rows carry a hand-typed response
  typedef struct {
    req_e                 kind;
    logic [PAYLOAD_W-1:0] data;
    int                   reps;
    bit                   fixed;
    ring_resp_t           want;
  } stim_row_t;

  localparam ring_resp_t RESP_NONE   = '{1'b0, 2'd0, 56'd0, 1'b0};
  localparam ring_resp_t RESP_ENQ_OK = '{1'b1, 2'd0, 56'd0, 1'b0};
  localparam logic [PAYLOAD_W-1:0] ALL_ONES = {PAYLOAD_W{1'b1}};
  localparam int TABLE_ROWS = 21;

  logic clk;
  logic rst;

  trrq_req_if req_ch();
  trrq_rsp_if rsp_ch();

  typed_report_ring_queue #(.RING_BYTES(RING)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the ring contents and pointers
  logic [7:0] ring_image [RING];
  int         wr_idx;
  int         rd_idx;

  ring_resp_t awaited_responses [$];
  stim_row_t  stim_table [TABLE_ROWS];

  int  mismatch_count;
  int  items_sent;
  int  idle_cycles = 0;
  int  n_enq_ok;
  int  n_enq_full;
  int  n_deq_ok;
  int  n_deq_empty;
  int  n_corrupt;
  int  n_wraps;
  bit  send_quiet;
  bit  recv_quiet;
  bit  long_hold_req;

  // Clock: period 4
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the ring image and return the response it should produce
  function automatic ring_resp_t ring_response(input req_e kind, input logic [PAYLOAD_W-1:0] data);
    ring_resp_t r;
    int         used;
    int         len;
    int         p;
    logic [7:0] tag;
    r    = RESP_NONE;
    used = (wr_idx + RING - rd_idx) % RING;
    if (kind != REQ_DEQUEUE) begin
      case (kind)
        REQ_KEY:      len = 7;
        REQ_CONSUMER: len = 2;
        default:      len = 4;
      endcase
      // Reject when the whole record does not fit
      if (len + 1 > RING - 1 - used) begin
        n_enq_full++;
        return r;
      end
      ring_image[wr_idx] = 8'(kind);
      p = (wr_idx + 1) % RING;
      for (int i = 0; i < len; i++) begin
        ring_image[p] = data[8*i +: 8];
        p = (p + 1) % RING;
      end
      if (p < wr_idx) n_wraps++;
      wr_idx = p;
      n_enq_ok++;
      r.ok = 1'b1;
      return r;
    end
    if (rd_idx == wr_idx) begin
      n_deq_empty++;
      return r;
    end
    tag = ring_image[rd_idx];
    // Unknown type byte: reset both pointers
    if (tag > 8'(REQ_MOUSE)) begin
      wr_idx = 0;
      rd_idx = 0;
      n_corrupt++;
      r.corrupt = 1'b1;
      return r;
    end
    case (tag[REQ_W-1:0])
      REQ_KEY:      len = 7;
      REQ_CONSUMER: len = 2;
      default:      len = 4;
    endcase
    p = (rd_idx + 1) % RING;
    for (int i = 0; i < len; i++) begin
      // Record cut short by the write pointer
      if (p == wr_idx) begin
        wr_idx = 0;
        rd_idx = 0;
        n_corrupt++;
        r.corrupt = 1'b1;
        return r;
      end
      r.rec_payload[8*i +: 8] = ring_image[p];
      p = (p + 1) % RING;
    end
    rd_idx     = p;
    r.ok       = 1'b1;
    r.rec_type = tag[REQ_W-1:0];
    n_deq_ok++;
    return r;
  endfunction

  // Offer one request, hold it until accepted, then queue its expected response
  task automatic send_request(input req_e kind, input logic [PAYLOAD_W-1:0] data,
                              input bit fixed, input ring_resp_t want);
    int         gap;
    ring_resp_t got;
    gap = send_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.payload  <= data;
    do @(posedge clk); while (!req_ch.ready);
    got = ring_response(kind, data);
    awaited_responses.push_back(fixed ? want : got);
    items_sent++;
  endtask

  // Stop offering and wait until every queued response has arrived
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [PAYLOAD_W-1:0] want,
                             input logic [PAYLOAD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random stalls, quiet stretches and one long hold on request
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      stall = recv_quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Compare each response transaction with the oldest expectation
  always @(posedge clk) begin
    ring_resp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_responses.size() == 0) begin
        $error("response transaction with no request outstanding");
        mismatch_count++;
      end else begin
        exp_r = awaited_responses.pop_front();
        check_field("ok", 56'(exp_r.ok), 56'(rsp_ch.ok));
        check_field("rec_type", 56'(exp_r.rec_type), 56'(rsp_ch.rec_type));
        check_field("rec_payload", exp_r.rec_payload, rsp_ch.rec_payload);
        check_field("corrupt", 56'(exp_r.corrupt), 56'(rsp_ch.corrupt));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("typed_report_ring_queue verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0]          rnd;
    req_e                 kind;
    int                   mode;
    int                   phase_len;
    int                   phase;
    stim_row_t            row;
    mismatch_count = 0;
    items_sent     = 0;
    n_enq_ok       = 0;
    n_enq_full     = 0;
    n_deq_ok       = 0;
    n_deq_empty    = 0;
    n_corrupt      = 0;
    n_wraps        = 0;
    wr_idx         = 0;
    rd_idx         = 0;
    send_quiet     = 1'b0;
    recv_quiet     = 1'b0;
    long_hold_req  = 1'b0;
    for (int i = 0; i < RING; i++) ring_image[i] = 8'd0;

    // Directed rows: extremes, every request, empty ring and full ring
    stim_table = '{
      '{REQ_DEQUEUE,  56'd0,               1,  1'b1, RESP_NONE},
      '{REQ_KEY,      ALL_ONES,            1,  1'b1, RESP_ENQ_OK},
      '{REQ_DEQUEUE,  56'd0,               1,  1'b1, '{1'b1, REQ_KEY, ALL_ONES, 1'b0}},
      '{REQ_CONSUMER, ALL_ONES,            1,  1'b1, RESP_ENQ_OK},
      '{REQ_DEQUEUE,  56'd0,               1,  1'b1, '{1'b1, REQ_CONSUMER, 56'hFFFF, 1'b0}},
      '{REQ_MOUSE,    ALL_ONES,            1,  1'b1, RESP_ENQ_OK},
      '{REQ_DEQUEUE,  56'd0,               1,  1'b1,
        '{1'b1, REQ_MOUSE, 56'hFFFF_FFFF, 1'b0}},
      '{REQ_DEQUEUE,  ALL_ONES,            1,  1'b1, RESP_NONE},
      '{REQ_KEY,      56'd0,               1,  1'b0, RESP_NONE},
      '{REQ_CONSUMER, 56'hAA55_AA55_AA55_AA, 1, 1'b0, RESP_NONE},
      '{REQ_MOUSE,    56'h55_AA55_AA55_AA55, 1, 1'b0, RESP_NONE},
      '{REQ_DEQUEUE,  56'd0,               3,  1'b0, RESP_NONE},
      '{REQ_DEQUEUE,  56'd0,               1,  1'b1, RESP_NONE},
      '{REQ_KEY,      56'h0123_4567_89AB_CD, 31, 1'b0, RESP_NONE},
      '{REQ_KEY,      ALL_ONES,            1,  1'b1, RESP_NONE},
      '{REQ_CONSUMER, 56'h00_0000_0000_8001, 1, 1'b0, RESP_NONE},
      '{REQ_MOUSE,    ALL_ONES,            1,  1'b1, RESP_NONE},
      '{REQ_CONSUMER, 56'h00_0000_0000_7FFE, 1, 1'b0, RESP_NONE},
      '{REQ_CONSUMER, ALL_ONES,            1,  1'b1, RESP_NONE},
      '{REQ_DEQUEUE,  56'd0,               34, 1'b0, RESP_NONE},
      '{REQ_DEQUEUE,  56'd0,               1,  1'b1, RESP_NONE}
    };

    // Hold reset with all inputs at known values
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_KEY;
    req_ch.payload  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < TABLE_ROWS; r++) begin
      row = stim_table[r];
      for (int k = 0; k < row.reps; k++) send_request(row.kind, row.data, row.fixed, row.want);
    end
    drain_responses();

    // Random phases: fill-heavy, drain-heavy or balanced, with random content
    phase = 0;
    while (items_sent < RANDOM_ITEMS + TABLE_ROWS) begin
      mode       = (phase == 2) ? 0 : $urandom_range(0, 2);
      phase_len  = $urandom_range(20, 80);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      // Stall the result side for a long stretch while requests keep coming
      if (phase == 2) long_hold_req = 1'b1;
      for (int k = 0; k < phase_len; k++) begin
        case (mode)
          0:       kind = ($urandom_range(0, 99) < 85) ? req_e'($urandom_range(0, 2)) : REQ_DEQUEUE;
          1:       kind = ($urandom_range(0, 99) < 85) ? REQ_DEQUEUE : req_e'($urandom_range(0, 2));
          default: kind = req_e'($urandom_range(0, 3));
        endcase
        rnd = {$urandom(), $urandom()};
        send_request(kind, rnd[PAYLOAD_W-1:0], 1'b0, RESP_NONE);
      end
      // Let the ring go idle now and then
      if (phase % 7 == 5) drain_responses();
      phase++;
    end

    // Wait out the last responses, then settle
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      $error("%0d expected responses never arrived", awaited_responses.size());
      mismatch_count++;
    end

    $display("requests: %0d sent, %0d enqueues stored, %0d rejected for lack of room",
             items_sent, n_enq_ok, n_enq_full);
    $display("dequeues: %0d records returned, %0d on empty ring, %0d corrupt; %0d pointer wraps",
             n_deq_ok, n_deq_empty, n_corrupt, n_wraps);
    if (mismatch_count == 0) begin
      $display("typed_report_ring_queue verification clean");
    end else begin
      $display("typed_report_ring_queue verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/trrq_pkg.sv
rtl/core/trrq_if.sv
rtl/core/trrq_dp.sv
rtl/core/trrq_ctrl.sv
rtl/core/typed_report_ring_queue.sv
tb/tb_typed_report_ring_queue.sv
